// ===== rtl/ptbl_pkg.sv =====
// shared constants, types and codes of the per-node token bucket limiter
// no dependencies
package ptbl_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  localparam int NODE_W = 32;
  localparam int MS_W   = 32;
  localparam int TOK_W  = 16;

  localparam int MS_PER_S = 1000;
  localparam int LIM_W    = TOK_W + $clog2(MS_PER_S);
  localparam int PROD_W   = TOK_W + MS_W - 1;

  // divide by 1000 as a shift by 3 and a multiply by the reciprocal of 125;
  // exact for every dividend below 2^LIM_W
  localparam int                 DIV_PRE     = 3;
  localparam int                 QIN_W       = LIM_W - DIV_PRE;
  localparam int                 RECIP_W     = 24;
  localparam logic [RECIP_W-1:0] RECIP_125   = 24'd8589935;
  localparam int                 RECIP_SHIFT = 30;
  localparam int                 QPROD_W     = QIN_W + RECIP_W;

  localparam logic [TOK_W-1:0] RATE_RESET = TOK_W'(MS_PER_S);

  localparam int FQ_DEPTH = 2;
  localparam int FQ_PTR_W = $clog2(FQ_DEPTH);
  localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);

  localparam logic [1:0] OUT_KNOWN_PASS = 2'd0;
  localparam logic [1:0] OUT_KNOWN_DENY = 2'd1;
  localparam logic [1:0] OUT_NEW        = 2'd2;
  localparam logic [1:0] OUT_FULL       = 2'd3;

  typedef struct packed {
    logic [NODE_W-1:0] node_id;
    logic [MS_W-1:0]   now_ms;
  } item_t;

  typedef struct packed {
    logic             vld;
    item_t            item;
  } fq_out_t;

  typedef struct packed {
    logic             allowed;
    logic [1:0]       outcome;
    logic [TOK_W-1:0] tokens_left;
  } result_t;

  typedef struct packed {
    logic [TOK_W-1:0] tokens;
    logic [MS_W-1:0]  last_ms;
    logic [TOK_W-1:0] rate;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== rtl/ptbl_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module ptbl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/ptbl_front.sv =====
// front end: accepts words into a short queue that feeds the back end
// depends on ptbl_pkg
module ptbl_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  output logic                     full,
  input  ptbl_pkg::item_t          item_in,
  output ptbl_pkg::fq_out_t        fq_out,
  input  logic                     fq_pop
);

  ptbl_pkg::item_t                   q_r [ptbl_pkg::FQ_DEPTH];
  logic [ptbl_pkg::FQ_PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [ptbl_pkg::FQ_PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [ptbl_pkg::FQ_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                              do_push, do_pop;

  assign full    = (cnt_r == ptbl_pkg::FQ_CNT_W'(ptbl_pkg::FQ_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = fq_pop && (cnt_r != '0);

  assign fq_out.vld  = (cnt_r != '0);
  assign fq_out.item = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == ptbl_pkg::FQ_PTR_W'(ptbl_pkg::FQ_DEPTH - 1)) ? '0
                   : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == ptbl_pkg::FQ_PTR_W'(ptbl_pkg::FQ_DEPTH - 1)) ? '0
                   : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

// ===== rtl/ptbl_back.sv =====
// back end: table search, refill arithmetic, registration and result register
// depends on ptbl_pkg and ptbl_ram
module ptbl_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ptbl_pkg::fq_out_t             fq_out,
  output logic                          fq_pop,
  input  logic                          cfg_wr_en,
  input  logic [ptbl_pkg::TOK_W-1:0]    cfg_wr_data,
  output logic                          res_vld,
  output ptbl_pkg::result_t             res,
  input  logic                          res_pop
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SRCH = 3'd1;
  localparam logic [2:0] S_NEW  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;
  localparam logic [2:0] S_SUM  = 3'd7;

  logic [2:0]                        state_r, state_nxt;
  logic [ptbl_pkg::TOK_W-1:0]        rate_cfg_r, rate_cfg_nxt;
  logic [ptbl_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [ptbl_pkg::CNT_W-1:0]        rd_idx_r, rd_idx_nxt;
  logic                              cmp_vld_r, cmp_vld_nxt;
  logic [ptbl_pkg::IDX_W-1:0]        cmp_idx_r, cmp_idx_nxt;
  logic [ptbl_pkg::IDX_W-1:0]        hit_idx_r, hit_idx_nxt;
  ptbl_pkg::item_t                   item_r, item_nxt;
  ptbl_pkg::entry_t                  ent_r, ent_nxt;
  logic                              ok_r, ok_nxt;
  logic [ptbl_pkg::PROD_W-1:0]       prod_r, prod_nxt;
  logic [ptbl_pkg::LIM_W-1:0]        lim_r, lim_nxt;
  logic [ptbl_pkg::LIM_W-1:0]        rem_r, rem_nxt;
  logic [ptbl_pkg::TOK_W-1:0]        quo_r, quo_nxt;
  logic [ptbl_pkg::TOK_W-1:0]        sum_r, sum_nxt;
  logic                              res_vld_r, res_vld_nxt;
  ptbl_pkg::result_t                 res_r, res_nxt;

  logic                              issue;
  logic                              room;
  logic [ptbl_pkg::MS_W-1:0]         diff;
  logic [ptbl_pkg::QPROD_W-1:0]      qprod;
  logic [ptbl_pkg::NODE_W-1:0]       node_rdata;
  logic [ptbl_pkg::ENTRY_W-1:0]      ent_rdata;
  logic                              node_we, ent_we;
  logic [ptbl_pkg::IDX_W-1:0]        ent_waddr;
  ptbl_pkg::entry_t                  ent_wdata;
  ptbl_pkg::entry_t                  ent_rd;

  assign issue  = (state_r == S_SRCH) && (rd_idx_r < cnt_r);
  assign room   = (cnt_r < ptbl_pkg::CNT_W'(ptbl_pkg::MAX_ENTRIES));
  assign diff   = item_r.now_ms - ent_r.last_ms;
  assign ent_rd = ptbl_pkg::entry_t'(ent_rdata);

  // reciprocal multiply for the divide by 1000
  assign qprod = ptbl_pkg::QPROD_W'(rem_r[ptbl_pkg::LIM_W-1:ptbl_pkg::DIV_PRE]) *
                 ptbl_pkg::QPROD_W'(ptbl_pkg::RECIP_125);

  assign node_we   = (state_r == S_NEW) && room;
  assign ent_we    = node_we || (state_r == S_FIN);
  assign ent_waddr = (state_r == S_NEW) ? cnt_r[ptbl_pkg::IDX_W-1:0] : hit_idx_r;

  always_comb begin
    ent_wdata = ent_r;
    if (state_r == S_NEW) begin
      ent_wdata.tokens  = rate_cfg_r;
      ent_wdata.last_ms = item_r.now_ms;
      ent_wdata.rate    = rate_cfg_r;
    end else begin
      ent_wdata.tokens  = (sum_r != '0) ? sum_r - 1'b1 : sum_r;
      ent_wdata.last_ms = ok_r ? item_r.now_ms : ent_r.last_ms;
    end
  end

  ptbl_ram #(
    .WIDTH (ptbl_pkg::NODE_W),
    .DEPTH (ptbl_pkg::MAX_ENTRIES)
  ) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (ent_waddr),
    .wdata (item_r.node_id),
    .re    (issue),
    .raddr (rd_idx_r[ptbl_pkg::IDX_W-1:0]),
    .rdata (node_rdata)
  );

  ptbl_ram #(
    .WIDTH (ptbl_pkg::ENTRY_W),
    .DEPTH (ptbl_pkg::MAX_ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .re    (issue),
    .raddr (rd_idx_r[ptbl_pkg::IDX_W-1:0]),
    .rdata (ent_rdata)
  );

  assign fq_pop = (state_r == S_IDLE) && fq_out.vld && !res_vld_r;

  always_comb begin
    state_nxt    = state_r;
    rate_cfg_nxt = cfg_wr_en ? cfg_wr_data : rate_cfg_r;
    cnt_nxt      = cnt_r;
    rd_idx_nxt   = rd_idx_r;
    cmp_vld_nxt  = issue;
    cmp_idx_nxt  = rd_idx_r[ptbl_pkg::IDX_W-1:0];
    hit_idx_nxt  = hit_idx_r;
    item_nxt     = item_r;
    ent_nxt      = ent_r;
    ok_nxt       = ok_r;
    prod_nxt     = prod_r;
    lim_nxt      = lim_r;
    rem_nxt      = rem_r;
    quo_nxt      = quo_r;
    sum_nxt      = sum_r;
    res_vld_nxt  = res_vld_r && !res_pop;
    res_nxt      = res_r;

    unique case (state_r)
      S_IDLE: begin
        if (fq_pop) begin
          item_nxt   = fq_out.item;
          rd_idx_nxt = '0;
          state_nxt  = S_SRCH;
        end
      end
      S_SRCH: begin
        // one entry read per cycle, compared in the cycle after its read
        if (issue) begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
        if (cmp_vld_r && (node_rdata == item_r.node_id)) begin
          hit_idx_nxt = cmp_idx_r;
          ent_nxt     = ent_rd;
          state_nxt   = S_MUL;
        end else if (!cmp_vld_r && !issue) begin
          state_nxt = S_NEW;
        end
      end
      S_NEW: begin
        res_vld_nxt = 1'b1;
        res_nxt.allowed = 1'b1;
        if (room) begin
          cnt_nxt             = cnt_r + 1'b1;
          res_nxt.outcome     = ptbl_pkg::OUT_NEW;
          res_nxt.tokens_left = rate_cfg_r;
        end else begin
          res_nxt.outcome     = ptbl_pkg::OUT_FULL;
          res_nxt.tokens_left = '0;
        end
        state_nxt = S_IDLE;
      end
      S_MUL: begin
        // refill only on a positive signed time difference
        ok_nxt   = (diff != '0) && !diff[ptbl_pkg::MS_W-1];
        prod_nxt = ptbl_pkg::PROD_W'(ent_r.rate) *
                   ptbl_pkg::PROD_W'(diff[ptbl_pkg::MS_W-2:0]);
        lim_nxt  = ptbl_pkg::LIM_W'(ent_r.rate - ent_r.tokens) *
                   ptbl_pkg::LIM_W'(ptbl_pkg::MS_PER_S);
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (!ok_r) begin
          sum_nxt   = ent_r.tokens;
          state_nxt = S_FIN;
        end else if (prod_r >= ptbl_pkg::PROD_W'(lim_r)) begin
          sum_nxt   = ent_r.rate;
          state_nxt = S_FIN;
        end else begin
          rem_nxt   = prod_r[ptbl_pkg::LIM_W-1:0];
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // quotient stays below the rate, so sixteen bits suffice
        quo_nxt   = qprod[ptbl_pkg::RECIP_SHIFT +: ptbl_pkg::TOK_W];
        state_nxt = S_SUM;
      end
      S_SUM: begin
        sum_nxt   = ent_r.tokens + quo_r;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        res_vld_nxt = 1'b1;
        if (sum_r != '0) begin
          res_nxt.allowed     = 1'b1;
          res_nxt.outcome     = ptbl_pkg::OUT_KNOWN_PASS;
          res_nxt.tokens_left = sum_r - 1'b1;
        end else begin
          res_nxt.allowed     = 1'b0;
          res_nxt.outcome     = ptbl_pkg::OUT_KNOWN_DENY;
          res_nxt.tokens_left = '0;
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      rate_cfg_r <= ptbl_pkg::RATE_RESET;
      cnt_r      <= '0;
      cmp_vld_r  <= 1'b0;
      res_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rate_cfg_r <= rate_cfg_nxt;
      cnt_r      <= cnt_nxt;
      cmp_vld_r  <= cmp_vld_nxt;
      res_vld_r  <= res_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r  <= rd_idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    hit_idx_r <= hit_idx_nxt;
    item_r    <= item_nxt;
    ent_r     <= ent_nxt;
    ok_r      <= ok_nxt;
    prod_r    <= prod_nxt;
    lim_r     <= lim_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    sum_r     <= sum_nxt;
    res_r     <= res_nxt;
  end

  assign res_vld = res_vld_r;
  assign res     = res_r;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ptbl_pkg::CNT_W'(ptbl_pkg::MAX_ENTRIES))
    else $error("entry count above table size");

  a_res_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(res_vld_r) |-> ($past(state_r) == S_NEW || $past(state_r) == S_FIN))
    else $error("result raised outside a finishing state");

  a_cnt_grow: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (cnt_r != $past(cnt_r)) |->
      (cnt_r == $past(cnt_r) + 1'b1) && (res_r.outcome == ptbl_pkg::OUT_NEW))
    else $error("entry count changed without a registration");

  a_deny_empty: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld_r && !res_r.allowed |->
      (res_r.outcome == ptbl_pkg::OUT_KNOWN_DENY) && (res_r.tokens_left == '0))
    else $error("denied word with tokens left");
`endif

endmodule

// ===== rtl/per_node_token_bucket_limiter.sv =====
// per-node token bucket limiter: each accepted word scans the table one entry per cycle
// (up to 64 entries); a new node is then registered, while a known one goes through
// the refill multiply, limit check, optional divide by 1000 and sum, then writes back
// the back end takes a new word only once it is idle and the last result is popped;
// a two-word input queue keeps taking words while the back end is busy
// synchronous active-low reset empties the table and queues, rate returns to 1000
module per_node_token_bucket_limiter (
  input  logic                           clk,
  input  logic                           rst_n,
  // input word
  input  logic                           push,
  output logic                           full,
  input  logic [ptbl_pkg::NODE_W-1:0]    in_node_id,
  input  logic [ptbl_pkg::MS_W-1:0]      in_now_ms,
  // result word
  output logic                           empty,
  input  logic                           pop,
  output logic                           out_allowed,
  output logic [1:0]                     out_outcome,
  output logic [ptbl_pkg::TOK_W-1:0]     out_tokens_left,
  // rate register, to be written only while idle; the block does not enforce this
  input  logic                           cfg_wr_en,
  input  logic [ptbl_pkg::TOK_W-1:0]     cfg_wr_data
);

  ptbl_pkg::item_t    item_in;
  ptbl_pkg::fq_out_t  fq_out;
  logic               fq_pop;
  logic               res_vld;
  ptbl_pkg::result_t  res;

  assign item_in.node_id = in_node_id;
  assign item_in.now_ms  = in_now_ms;

  // front: input queue, push accepted whenever a slot is free
  ptbl_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .item_in (item_in),
    .fq_out  (fq_out),
    .fq_pop  (fq_pop)
  );

  // back: table scan, refill and registration; takes a word once it is idle
  // and its result register is free
  ptbl_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .fq_out      (fq_out),
    .fq_pop      (fq_pop),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .res_vld     (res_vld),
    .res         (res),
    .res_pop     (pop)
  );

  // result register drives the output queue face
  assign empty           = !res_vld;
  assign out_allowed     = res.allowed;
  assign out_outcome     = res.outcome;
  assign out_tokens_left = res.tokens_left;

endmodule
